FILE: hdl/bm3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bm3_pkg;

  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OP_MODE      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_MASK = 2'd3;

  localparam int CFG_RST_WIDTH  = 10;
  localparam int CFG_RST_HEIGHT = 10;
  localparam logic [8:0] CFG_RST_MASK = 9'd186;

  localparam logic OP_DILATE = 1'b0;
  localparam logic OP_ERODE  = 1'b1;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam int OUT_DEPTH  = 3;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic any;
    logic or_v;
    logic and_v;
  } bm3_part_t;

  typedef struct packed {
    logic pix;
    logic row_end;
    logic image_end;
  } bm3_res_t;

endpackage

`default_nettype wire

FILE: hdl/binary_morphology_3x3.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming 3x3 binary dilation or erosion. One word is accepted per clock while
// the output queue has room; each word is one pixel in raster order. The first
// result of an image comes with input word image_width+1, so after the last pixel
// image_width+1 drain words flush the rest; the last result carries image_end. A
// single dual-port line store of MAX_WIDTH entries holds the two previous rows and
// is read in the cycle before its write-back, and three column cells hold the
// window. Writing image_width or image_height restarts the image; op_mode and
// element_mask act at once.
module binary_morphology_3x3
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   func,
  input  logic                   pixel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   result_pixel,
  output logic                   row_end,
  output logic                   image_end,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int IRW = $clog2(MAX_HEIGHT + 2);
  localparam logic [CW-1:0] W_M1_RST =
    CW'(((CFG_RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : CFG_RST_WIDTH) - 1);
  localparam logic [RW-1:0] H_M1_RST =
    RW'(((CFG_RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RST_HEIGHT) - 1);

  logic [CW-1:0]  w_m1;
  logic [RW-1:0]  h_m1;
  logic           op_mode;
  logic [8:0]     element_mask;
  logic [CW-1:0]  cfg_w_m1;
  logic [RW-1:0]  cfg_h_m1;

  logic [CW-1:0]  in_col;
  logic [IRW-1:0] in_row;
  logic [CW-1:0]  out_col;
  logic [RW-1:0]  out_row;

  logic accept, beyond, has_out, last_in_col, last_out_col, last_img, pix_in;

  logic           s1_valid;
  logic           s1_pix;
  logic [CW-1:0]  s1_col;
  logic           s1_has_out;
  logic [2:0]     s1_row_ok;
  logic           s1_left_ok;
  logic           s1_right_ok;
  logic           s1_row_end;
  logic           s1_image_end;
  logic           byp;
  logic           byp_up;
  logic           byp_mid;

  logic [1:0]     ram_rdata;
  logic           rd_up, rd_mid;
  logic [2:0]     col_new;
  logic [2:0]     col_c1, col_c2;
  bm3_part_t      part0, part1, part2;
  logic           or_all, and_all, any_all, res_pix;

  bm3_res_t              fifo_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [OUT_CNT_W-1:0]  count;
  logic                  push, pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (32'(cfg_data) > MAX_WIDTH) begin
      cfg_w_m1 = CW'(MAX_WIDTH - 1);
    end else if (cfg_data == '0) begin
      cfg_w_m1 = '0;
    end else begin
      cfg_w_m1 = CW'(cfg_data - CFG_DATA_W'(1));
    end
    if (32'(cfg_data) > MAX_HEIGHT) begin
      cfg_h_m1 = RW'(MAX_HEIGHT - 1);
    end else if (cfg_data == '0) begin
      cfg_h_m1 = '0;
    end else begin
      cfg_h_m1 = RW'(cfg_data - CFG_DATA_W'(1));
    end
  end

  always_comb begin
    accept       = in_valid && in_ready;
    last_in_col  = (in_col == w_m1);
    beyond       = (in_row > IRW'(h_m1));
    has_out      = (in_row != '0) && ((in_row != IRW'(1)) || (in_col != '0));
    last_out_col = (out_col == w_m1);
    last_img     = last_out_col && (out_row == h_m1);
    pix_in       = (func == FUNC_PIXEL) && pixel && !beyond;
  end

  always_comb begin
    rd_up   = byp ? byp_up  : ram_rdata[1];
    rd_mid  = byp ? byp_mid : ram_rdata[0];
    col_new = {s1_pix, rd_mid, rd_up};
  end

  bm3_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata ({rd_mid, s1_pix}),
    .re    (accept),
    .raddr (in_col),
    .rdata (ram_rdata)
  );

  bm3_cell u_cell2 (
    .clk     (clk),
    .shift   (s1_valid),
    .col_in  (col_new),
    .msk     ({element_mask[8], element_mask[5], element_mask[2]}),
    .ok      (s1_row_ok & {3{s1_right_ok}}),
    .col_out (col_c2),
    .part    (part2)
  );

  bm3_cell u_cell1 (
    .clk     (clk),
    .shift   (s1_valid),
    .col_in  (col_c2),
    .msk     ({element_mask[7], element_mask[4], element_mask[1]}),
    .ok      (s1_row_ok),
    .col_out (col_c1),
    .part    (part1)
  );

  bm3_cell u_cell0 (
    .clk     (clk),
    .shift   (s1_valid),
    .col_in  (col_c1),
    .msk     ({element_mask[6], element_mask[3], element_mask[0]}),
    .ok      (s1_row_ok & {3{s1_left_ok}}),
    .col_out (),
    .part    (part0)
  );

  always_comb begin
    or_all  = part0.or_v  | part1.or_v  | part2.or_v;
    and_all = part0.and_v & part1.and_v & part2.and_v;
    any_all = part0.any   | part1.any   | part2.any;
    res_pix = (op_mode == OP_ERODE) ? (and_all & any_all) : or_all;
  end

  assign push      = s1_valid && s1_has_out;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign in_ready  = (({1'b0, count} + (OUT_CNT_W + 1)'(s1_valid))
                      < (OUT_CNT_W + 1)'(OUT_DEPTH));

  assign result_pixel = fifo_mem[rd_ptr].pix;
  assign row_end      = fifo_mem[rd_ptr].row_end;
  assign image_end    = fifo_mem[rd_ptr].image_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1         <= W_M1_RST;
      h_m1         <= H_M1_RST;
      op_mode      <= OP_DILATE;
      element_mask <= CFG_RST_MASK;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      s1_valid     <= 1'b0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (has_out && last_img) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else begin
          if (last_in_col) begin
            in_col <= '0;
            in_row <= in_row + IRW'(1);
          end else begin
            in_col <= in_col + CW'(1);
          end
          if (has_out) begin
            if (last_out_col) begin
              out_col <= '0;
              out_row <= out_row + RW'(1);
            end else begin
              out_col <= out_col + CW'(1);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            w_m1    <= cfg_w_m1;
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
          end
          REG_IMAGE_HEIGHT: begin
            h_m1    <= cfg_h_m1;
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
          end
          REG_OP_MODE: begin
            op_mode <= cfg_data[0];
          end
          REG_ELEMENT_MASK: begin
            element_mask <= cfg_data[8:0];
          end
          default: begin
          end
        endcase
      end
      if (push) begin
        wr_ptr <= (wr_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + OUT_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + OUT_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - OUT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix       <= pix_in;
      s1_col       <= in_col;
      s1_has_out   <= has_out;
      s1_row_ok    <= {out_row != h_m1, 1'b1, out_row != '0};
      s1_left_ok   <= (out_col != '0);
      s1_right_ok  <= !last_out_col;
      s1_row_end   <= last_out_col;
      s1_image_end <= last_img;
      // Same line store entry written back in this cycle: its read is stale.
      byp          <= s1_valid && (s1_col == in_col);
      byp_up       <= rd_mid;
      byp_mid      <= s1_pix;
    end
    if (push) begin
      fifo_mem[wr_ptr] <= '{pix: res_pix, row_end: s1_row_end, image_end: s1_image_end};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count != OUT_CNT_W'(OUT_DEPTH)))
    else $error("Output queue overflow.");

  assert property (@(posedge clk) disable iff (rst)
    (accept && has_out && last_img) |=>
      (in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0))
    else $error("Counters did not restart after the last result of the image.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && image_end) |-> row_end)
    else $error("Image end without row end.");

  assert property (@(posedge clk) disable iff (rst)
    in_row <= (IRW'(h_m1) + IRW'(2)))
    else $error("Input row counter ran past the image.");

endmodule

`default_nettype wire

FILE: hdl/bm3_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bm3_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bm3_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bm3_cell
  import bm3_pkg::*;
(
  input  logic       clk,
  input  logic       shift,
  input  logic [2:0] col_in,
  input  logic [2:0] msk,
  input  logic [2:0] ok,
  output logic [2:0] col_out,
  output bm3_part_t  part
);

  logic [2:0] col;

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

  // The partial terms describe the column as it stands after this shift.
  always_comb begin
    part.any   = |msk;
    part.or_v  = |(msk & ok & col_in);
    part.and_v = &(~msk | (ok & col_in));
  end

endmodule

`default_nettype wire

FILE: test/binary_morphology_3x3_tb.sv
`timescale 1ns / 1ps

module binary_morphology_3x3_tb
  import bm3_pkg::*;
();

  localparam int MAX_DIM = 1024;
  localparam int HIST_LEN = 2 * MAX_DIM + 4;

  localparam logic [3:0] SET_OP   = 4'b1100;
  localparam logic [3:0] SET_ALL  = 4'b1111;

  localparam logic [8:0] MASK_FULL   = 9'h1FF;
  localparam logic [8:0] MASK_CENTRE = 9'h010;
  localparam logic [8:0] MASK_EMPTY  = 9'h000;

  typedef struct {
    logic pix;
    logic row_end;
    logic image_end;
    int   row;
    int   col;
  } window_result_t;

  class morph_checker;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic                  mode_reg;
    logic [8:0]            mask_reg;
    bit                    history [HIST_LEN];
    int                    head;
    int                    in_count;
    int                    out_row;
    int                    out_col;
    window_result_t        pending_results [$];
    int unsigned           errors;
    int unsigned           words;
    int unsigned           results;
    int unsigned           images;
    int unsigned           reg_writes;

    function new();
      width_reg = CFG_DATA_W'(CFG_RST_WIDTH);
      height_reg = CFG_DATA_W'(CFG_RST_HEIGHT);
      mode_reg = OP_DILATE;
      mask_reg = CFG_RST_MASK;
      foreach (history[i]) history[i] = 1'b0;
      head = 0;
      restart_image();
    endfunction

    function void restart_image();
      in_count = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    function int clamp_dim(int v);
      if (v < 1) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = data;
          restart_image();
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = data;
          restart_image();
        end
        REG_OP_MODE: mode_reg = data[0];
        REG_ELEMENT_MASK: mask_reg = data[8:0];
        default: ;
      endcase
    endfunction

    function void accept_word(logic f, logic p);
      int w;
      int h;
      int newest;
      int rr;
      int cc;
      bit v;
      bit tap;
      bit acc_or;
      bit acc_and;
      bit any;
      window_result_t res;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      v = (f == FUNC_DRAIN) ? 1'b0 : p;
      if (in_count >= w * h) v = 1'b0;
      head = (head + 1) % HIST_LEN;
      history[head] = v;
      newest = in_count;
      in_count++;
      words++;
      if (newest < w + 1) return;
      acc_or = 1'b0;
      acc_and = 1'b1;
      any = 1'b0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if (mask_reg[(dr + 1) * 3 + dc + 1]) begin
            any = 1'b1;
            tap = 1'b0;
            rr = out_row + dr;
            cc = out_col + dc;
            if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
              tap = history[(head + HIST_LEN - (w + 1) + dr * w + dc) % HIST_LEN];
            end
            acc_or |= tap;
            acc_and &= tap;
          end
        end
      end
      if (!any) acc_and = 1'b0;
      res.pix = (mode_reg == OP_ERODE) ? acc_and : acc_or;
      res.row_end = (out_col == w - 1);
      res.image_end = res.row_end && (out_row == h - 1);
      res.row = out_row;
      res.col = out_col;
      pending_results.push_back(res);
      if (res.image_end) begin
        images++;
        restart_image();
      end else if (res.row_end) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    endfunction

    function void compare_field(string name, logic exp_v, logic act_v, int row, int col);
      if (act_v !== exp_v) begin
        errors++;
        if (errors <= 50) begin
          $display("%0t: %s at row %0d col %0d: expected %0b, actual %0b",
                   $time, name, row, col, exp_v, act_v);
        end
      end
    endfunction

    function void check_result(logic pix, logic re, logic ie);
      window_result_t res;
      results++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 50) begin
          $display("%0t: result word with none expected: expected nothing, actual %0b%0b%0b",
                   $time, pix, re, ie);
        end
        return;
      end
      res = pending_results.pop_front();
      compare_field("result_pixel", res.pix, pix, res.row, res.col);
      compare_field("row_end", res.row_end, re, res.row, res.col);
      compare_field("image_end", res.image_end, ie, res.row, res.col);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   func = FUNC_PIXEL;
  logic                   pixel = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   result_pixel;
  logic                   row_end;
  logic                   image_end;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  morph_checker sb;
  bit           idle_on = 1'b1;
  int           burst_left = 0;
  bit           long_hold_req = 1'b0;
  int           hold_left = 0;
  int           slot = 0;
  bit [31:0]    ready_bits = '1;

  binary_morphology_3x3 #(
    .MAX_WIDTH(MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_pixel(result_pixel),
    .row_end(row_end),
    .image_end(image_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.accept_word(func, pixel);
      if (out_valid && out_ready) sb.check_result(result_pixel, row_end, image_end);
    end
  end

  // The receiver replays a random 32-bit ready pattern and can be told to
  // hold off for a long stretch so the block backs up into its input.
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 400;
    end
    if (slot == 0) begin
      case ($urandom_range(0, 3))
        0: ready_bits = '1;
        1: ready_bits = $urandom;
        2: ready_bits = $urandom | $urandom;
        default: ready_bits = $urandom & $urandom;
      endcase
    end
    slot = (slot + 1) % 32;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ready_bits[slot];
    end
  end

  task automatic send_word(input logic f, input logic p);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (idle_on && $urandom_range(0, 3) != 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= f;
    pixel <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_image(input int w, input int h, input int density,
                            input int noise_pct, input int drain_extra);
    logic pix;
    for (int k = 0; k < w * h; k++) begin
      pix = ($urandom_range(0, 99) < density);
      if ($urandom_range(0, 99) < noise_pct) send_word(FUNC_DRAIN, pix);
      else send_word(FUNC_PIXEL, pix);
    end
    for (int k = 0; k < w + 1 + drain_extra; k++) begin
      pix = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < noise_pct) send_word(FUNC_PIXEL, pix);
      else send_word(FUNC_DRAIN, pix);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do begin
      while (sb.pending_results.size() != 0) @(posedge clk);
      repeat (8) @(posedge clk);
    end while (sb.pending_results.size() != 0);
  endtask

  task automatic write_one(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_config(input logic [3:0] which, input logic [CFG_DATA_W-1:0] w,
                              input logic [CFG_DATA_W-1:0] h, input logic mode,
                              input logic [8:0] mask);
    settle();
    if (which[0]) write_one(REG_IMAGE_WIDTH, w);
    if (which[1]) write_one(REG_IMAGE_HEIGHT, h);
    if (which[2]) write_one(REG_OP_MODE, CFG_DATA_W'(mode));
    if (which[3]) write_one(REG_ELEMENT_MASK, CFG_DATA_W'(mask));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] w_val;
    logic [CFG_DATA_W-1:0] h_val;
    logic [8:0]            mask_val;
    logic                  mode_val;
    int                    density;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    long_hold_req = 1'b1;
    send_image(CFG_RST_WIDTH, CFG_RST_HEIGHT, 60, 0, 0);

    apply_config(SET_ALL, 0, 0, OP_DILATE, MASK_FULL);
    send_word(FUNC_PIXEL, 1'b1);
    send_word(FUNC_PIXEL, 1'b1);
    send_word(FUNC_DRAIN, 1'b1);

    apply_config(SET_ALL, 3, 2, OP_ERODE, MASK_CENTRE);
    send_word(FUNC_PIXEL, 1'b1);
    send_word(FUNC_PIXEL, 1'b0);
    send_word(FUNC_DRAIN, 1'b1);
    repeat (3) send_word(FUNC_PIXEL, 1'b1);
    repeat (4) send_word(FUNC_DRAIN, 1'b0);

    apply_config(SET_OP, 0, 0, OP_DILATE, MASK_EMPTY);
    repeat (6) send_word(FUNC_PIXEL, 1'b1);
    repeat (4) send_word(FUNC_DRAIN, 1'b1);

    while (sb.words < 650) begin
      w_val = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 40))
                                          : CFG_DATA_W'($urandom_range(1, 12));
      h_val = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 20))
                                          : CFG_DATA_W'($urandom_range(1, 8));
      mode_val = $urandom_range(0, 1) ? OP_ERODE : OP_DILATE;
      case ($urandom_range(0, 4))
        0: mask_val = MASK_FULL;
        1: mask_val = MASK_EMPTY;
        2: mask_val = CFG_RST_MASK;
        default: mask_val = 9'($urandom_range(0, 511));
      endcase
      apply_config(4'($urandom_range(0, 15)), w_val, h_val, mode_val, mask_val);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        density = ($urandom_range(0, 4) == 0) ? 100 * $urandom_range(0, 1)
                                              : $urandom_range(20, 95);
        send_image(sb.clamp_dim(sb.width_reg), sb.clamp_dim(sb.height_reg), density,
                   ($urandom_range(0, 3) == 0) ? 5 : 0,
                   ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, 6)) - 3 : 0);
      end
    end

    settle();
    $display("Checked %0d result words from %0d input words over %0d images.",
             sb.results, sb.words, sb.images);
    $display("Covered %0d register writes: both operations, sizes 0 to 40, drains.",
             sb.reg_writes);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bm3_pkg.sv
hdl/bm3_ram.sv
hdl/bm3_cell.sv
hdl/binary_morphology_3x3.sv
test/binary_morphology_3x3_tb.sv
